/* hdl/bdel_pkg.sv */
// bdel_pkg: shared constants, command and status codes for the bounded double-ended list
// depends on nothing; used by bdel_ctrl and bounded_double_ended_list
`timescale 1ns / 1ps

package bdel_pkg;

  // ring store geometry
  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;

  // port widths fixed by the interface
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 2;

  // width for comparing an index against the count
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_BACK  = 3'd0,
    CMD_ADD_FRONT = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // memory request from the control to the store
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  // bring a slot sum below DEPTH (the sum is always under twice DEPTH)
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] red;
    red = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    return PTR_W'(red);
  endfunction

endpackage

/* hdl/bdel_ram.sv */
// bdel_ram: generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module bdel_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bdel_ctrl.sv */
// bdel_ctrl: front pointer, item count and command decode for the ring store
// depends on bdel_pkg; drives the store request and the result registers
`timescale 1ns / 1ps

module bdel_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [bdel_pkg::CMD_W-1:0]        command,
  input  logic signed [bdel_pkg::DATA_W-1:0] value,
  input  logic [bdel_pkg::IDX_W-1:0]        index,
  output bdel_pkg::mem_req_t                req,
  output logic                              done,
  output logic                              rd_ok,
  output logic [bdel_pkg::CNT_W-1:0]        count,
  output bdel_pkg::status_t                 status
);

  logic [bdel_pkg::PTR_W-1:0] front;
  logic [bdel_pkg::PTR_W-1:0] front_next;
  logic [bdel_pkg::CNT_W-1:0] count_next;
  bdel_pkg::status_t          status_next;
  logic                       rd_ok_next;
  logic                       full;
  logic                       empty;
  logic                       in_range;
  logic [bdel_pkg::PTR_W-1:0] back_slot;
  logic [bdel_pkg::PTR_W-1:0] read_slot;
  logic [bdel_pkg::PTR_W-1:0] front_dec;
  logic [bdel_pkg::PTR_W-1:0] front_inc;

  assign full     = (count >= bdel_pkg::CNT_W'(bdel_pkg::DEPTH));
  assign empty    = (count == '0);
  assign in_range = (bdel_pkg::CMP_W'(index) < bdel_pkg::CMP_W'(count));

  // ring slot arithmetic
  assign back_slot = bdel_pkg::wrap_slot(bdel_pkg::SUM_W'(front) + bdel_pkg::SUM_W'(count));
  assign read_slot = bdel_pkg::wrap_slot(bdel_pkg::SUM_W'(front) + bdel_pkg::SUM_W'(index));
  assign front_dec = (front == '0) ? bdel_pkg::PTR_W'(bdel_pkg::DEPTH - 1)
                                   : front - bdel_pkg::PTR_W'(1);
  assign front_inc = (front == bdel_pkg::PTR_W'(bdel_pkg::DEPTH - 1)) ? '0
                                   : front + bdel_pkg::PTR_W'(1);

  // command decode
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = bdel_pkg::ST_OK;
    rd_ok_next  = 1'b0;
    req.we      = 1'b0;
    req.waddr   = back_slot;
    req.wdata   = value;
    req.re      = 1'b0;
    req.raddr   = read_slot;
    if (accept) begin
      case (bdel_pkg::cmd_t'(command))
        bdel_pkg::CMD_ADD_BACK: begin
          if (full) begin
            status_next = bdel_pkg::ST_FULL;
          end else begin
            req.we     = 1'b1;
            count_next = count + bdel_pkg::CNT_W'(1);
          end
        end
        bdel_pkg::CMD_ADD_FRONT: begin
          req.waddr = front_dec;
          if (full) begin
            status_next = bdel_pkg::ST_FULL;
          end else begin
            req.we     = 1'b1;
            front_next = front_dec;
            count_next = count + bdel_pkg::CNT_W'(1);
          end
        end
        bdel_pkg::CMD_REM_FRONT: begin
          if (empty) begin
            status_next = bdel_pkg::ST_EMPTY;
          end else begin
            front_next = front_inc;
            count_next = count - bdel_pkg::CNT_W'(1);
          end
        end
        bdel_pkg::CMD_REM_BACK: begin
          if (empty) begin
            status_next = bdel_pkg::ST_EMPTY;
          end else begin
            count_next = count - bdel_pkg::CNT_W'(1);
          end
        end
        bdel_pkg::CMD_READ: begin
          if (in_range) begin
            req.re     = 1'b1;
            rd_ok_next = 1'b1;
          end else begin
            status_next = bdel_pkg::ST_OOB;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      done  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      done  <= accept;
      rd_ok <= rd_ok_next;
    end
  end

  // result status, only meaningful while done is high
  always_ff @(posedge clk) begin
    status <= status_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdel_pkg::CNT_W'(bdel_pkg::DEPTH))
    else $error("item count beyond store depth");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without accepted word");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    accept && empty && (command == bdel_pkg::CMD_REM_FRONT || command == bdel_pkg::CMD_REM_BACK)
    |=> status == bdel_pkg::ST_EMPTY && $stable(count) && $stable(front))
    else $error("remove from empty list changed state");

  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && command == bdel_pkg::CMD_READ |=> $stable(count) && $stable(front))
    else $error("read changed ring state");

endmodule

/* hdl/bounded_double_ended_list.sv */
// bounded_double_ended_list: top level of the bounded double-ended list
// depends on bdel_pkg, bdel_ctrl and bdel_ram
`timescale 1ns / 1ps

// Usage
//   A command word (command, value, index) is taken at a rising edge where
//   start is high and busy is low. busy stays low: a new word may be given
//   every cycle.
//   Commands: add at back, add at front, remove front, remove back, read at
//   index. Each word gives exactly one result on read_value, count and
//   status, marked by done for one cycle, the cycle right after the word is
//   taken (throughput one word per cycle).
//   The list sits in a single ring memory addressed from a front pointer;
//   each word makes at most one memory access, and a read returns data from
//   the registered memory port in the result cycle. A write is visible to a
//   read issued in the next cycle, so no forwarding path is needed.
//   Reset (rst, synchronous) empties the list and clears done; memory
//   contents are not cleared and are never returned before being written.
//   The receiver cannot stall: each result is valid for its one cycle only.

module bounded_double_ended_list (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bdel_pkg::CMD_W-1:0]          command,
  input  logic signed [bdel_pkg::DATA_W-1:0]  value,
  input  logic [bdel_pkg::IDX_W-1:0]          index,
  output logic                                done,
  output logic signed [bdel_pkg::DATA_W-1:0]  read_value,
  output logic [bdel_pkg::COUNT_W-1:0]        count,
  output logic [bdel_pkg::STAT_W-1:0]         status
);

  bdel_pkg::mem_req_t          req;
  bdel_pkg::status_t           st;
  logic                        rd_ok;
  logic                        accept;
  logic [bdel_pkg::CNT_W-1:0]  cnt;
  logic [bdel_pkg::DATA_W-1:0] rdata;

  // busy stays low: the list never stalls a command
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bdel_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .value   (value),
    .index   (index),
    .req     (req),
    .done    (done),
    .rd_ok   (rd_ok),
    .count   (cnt),
    .status  (st)
  );

  bdel_ram #(
    .WIDTH (bdel_pkg::DATA_W),
    .DEPTH (bdel_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  // result word
  assign read_value = rd_ok ? $signed(rdata) : '0;
  assign count      = bdel_pkg::COUNT_W'(cnt);
  assign status     = st;

endmodule
